// ===== rtl/trma_pkg.sv =====
`timescale 1ns / 1ps

package trma_pkg;

   localparam int DATA_W      = 32;
   localparam int SUM_W       = 48;
   localparam int SCALE_W     = 17;
   localparam int DIM_REG_W   = 11;
   localparam int BATCH_REG_W = 9;
   localparam int EFF_W       = 17;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_W      = SUM_W + SCALE_W + 1;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MAX_BATCH_DEF  = 256;

   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [DATA_W-1:0] MEAN_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MEAN_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic                   AXIS_RESET  = 1'b1;
   localparam logic [DIM_REG_W-1:0]   DIM_RESET   = DIM_REG_W'(1);
   localparam logic [BATCH_REG_W-1:0] BATCH_RESET = BATCH_REG_W'(1);
   localparam logic [SCALE_W-1:0]     SCALE_RESET = SCALE_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS   = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_WIDTH  = 3'd2,
      CSR_BATCH  = 3'd3,
      CSR_SCALE  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                   axis_select;
      logic [DIM_REG_W-1:0]   height_count;
      logic [DIM_REG_W-1:0]   width_count;
      logic [BATCH_REG_W-1:0] batch_count;
      logic [SCALE_W-1:0]     reciprocal_scale;
   } cfg_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic                    tensor_last;
   } accum_word_type;

   // A count of zero acts as one; counts above the limit are clamped to it.
   function automatic logic [EFF_W-1:0] eff_count(input logic [DIM_REG_W-1:0] value,
                                                  input int maxv);
      logic [EFF_W-1:0] result;
      if (value == '0) begin
         result = EFF_W'(1);
      end else if (int'(value) > maxv) begin
         result = EFF_W'(maxv);
      end else begin
         result = EFF_W'(value);
      end
      return result;
   endfunction

endpackage

// ===== rtl/trma_if.sv =====
`timescale 1ns / 1ps

interface trma_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [trma_pkg::DATA_W-1:0]   sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

interface trma_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [trma_pkg::DATA_W-1:0]   mean_value;
   logic                                 tensor_last;

   modport source (output valid, output mean_value, output tensor_last, input ready);
   modport sink   (input valid, input mean_value, input tensor_last, output ready);
endinterface

interface trma_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [trma_pkg::CSR_IDX_W-1:0]       index;
   logic [trma_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/trma_ram.sv =====
`timescale 1ns / 1ps

module trma_ram #(
   parameter int DATA_W = 48,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/trma_accum.sv =====
`timescale 1ns / 1ps

module trma_accum #(
   parameter int MAX_WIDTH  = trma_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = trma_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_BATCH  = trma_pkg::MAX_BATCH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  trma_pkg::cfg_type                  cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [trma_pkg::DATA_W-1:0] in_sample,
   output logic                               out_valid,
   input  logic                               out_ready,
   output trma_pkg::accum_word_type           out_word
);

   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SLICE_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int SUM_W   = trma_pkg::SUM_W;
   localparam int EFF_W   = trma_pkg::EFF_W;

   logic [COL_W-1:0]   col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]   row_pos_ff, row_pos_in;
   logic [SLICE_W-1:0] slice_pos_ff, slice_pos_in;
   logic [EFF_W-1:0]   w_eff, h_eff, n_eff;
   logic               col_last, row_last, slice_last;
   logic               accept, axis0;

   logic                              a_valid_ff, a_valid_in;
   logic signed [trma_pkg::DATA_W-1:0] a_x_ff;
   logic                              a_row0_ff, a_emit_ff, a_last_ff;
   logic [COL_W-1:0]                  a_col_ff;
   logic                              a_fwd_ff, a_fwd_in;
   logic signed [SUM_W-1:0]           a_fwd_data_ff;
   logic                              a_adv;

   logic signed [SUM_W-1:0] row_sum_ff, row_sum_in;
   logic signed [SUM_W-1:0] rd_data, prev_sum, x_ext, a_sum;
   logic                    wr_en;

   always_comb begin
      w_eff = trma_pkg::eff_count(cfg.width_count, MAX_WIDTH);
      h_eff = trma_pkg::eff_count(cfg.height_count, MAX_HEIGHT);
      n_eff = trma_pkg::eff_count(trma_pkg::DIM_REG_W'(cfg.batch_count), MAX_BATCH);
      col_last   = EFF_W'(col_pos_ff) >= (w_eff - EFF_W'(1));
      row_last   = EFF_W'(row_pos_ff) >= (h_eff - EFF_W'(1));
      slice_last = EFF_W'(slice_pos_ff) >= (n_eff - EFF_W'(1));
   end

   assign axis0    = (cfg.axis_select == 1'b0);
   assign a_adv    = a_valid_ff && (!a_emit_ff || out_ready);
   assign in_ready = !a_valid_ff || a_adv;
   assign accept   = in_valid && in_ready;

   always_comb begin
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      slice_pos_in = slice_pos_ff;
      if (accept) begin
         if (col_last) begin
            col_pos_in = '0;
            if (row_last) begin
               row_pos_in   = '0;
               slice_pos_in = slice_last ? '0 : slice_pos_ff + SLICE_W'(1);
            end else begin
               row_pos_in = row_pos_ff + ROW_W'(1);
            end
         end else begin
            col_pos_in = col_pos_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      x_ext    = {{(SUM_W - trma_pkg::DATA_W){a_x_ff[trma_pkg::DATA_W-1]}}, a_x_ff};
      prev_sum = a_fwd_ff ? a_fwd_data_ff : rd_data;
      if (axis0) begin
         a_sum = a_row0_ff ? x_ext : prev_sum + x_ext;
      end else begin
         a_sum = row_sum_ff + x_ext;
      end
   end

   // The column entry written this cycle is not yet visible to a read at
   // the same edge, so the new sum is carried along instead.
   assign wr_en      = a_adv && axis0;
   assign a_fwd_in   = wr_en && (a_col_ff == col_pos_ff);
   assign a_valid_in = accept || (a_valid_ff && !a_adv);

   always_comb begin
      row_sum_in = row_sum_ff;
      if (a_adv && !axis0) begin
         row_sum_in = a_emit_ff ? '0 : a_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         slice_pos_ff <= '0;
         a_valid_ff   <= 1'b0;
         row_sum_ff   <= '0;
      end else begin
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         slice_pos_ff <= slice_pos_in;
         a_valid_ff   <= a_valid_in;
         row_sum_ff   <= row_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_x_ff        <= in_sample;
         a_row0_ff     <= (row_pos_ff == '0);
         a_emit_ff     <= axis0 ? row_last : col_last;
         a_last_ff     <= col_last && row_last && slice_last;
         a_col_ff      <= col_pos_ff;
         a_fwd_ff      <= a_fwd_in;
         a_fwd_data_ff <= a_sum;
      end
   end

   trma_ram #(
      .DATA_W (SUM_W),
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_col_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (a_col_ff),
      .wr_data (a_sum),
      .rd_en   (accept),
      .rd_addr (col_pos_ff),
      .rd_data (rd_data)
   );

   assign out_valid            = a_valid_ff && a_emit_ff;
   assign out_word.sum         = a_sum;
   assign out_word.tensor_last = a_last_ff;

endmodule

// ===== rtl/trma_scale.sv =====
`timescale 1ns / 1ps

module trma_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [trma_pkg::SCALE_W-1:0]        scale,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  trma_pkg::accum_word_type            in_word,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [trma_pkg::DATA_W-1:0]  out_mean,
   output logic                                out_last
);

   localparam int PROD_W = trma_pkg::PROD_W;
   localparam int DATA_W = trma_pkg::DATA_W;
   localparam int SUM_W  = trma_pkg::SUM_W;

   logic                    b_valid_ff, c_valid_ff, o_valid_ff;
   logic                    b_ready, c_ready, o_ready;
   logic signed [SUM_W-1:0] b_sum_ff;
   logic                    b_last_ff, c_last_ff, o_last_ff;
   logic signed [PROD_W-1:0] c_prod_ff, c_prod_in;
   logic signed [PROD_W-1:0] rounded, shifted;
   logic [PROD_W-DATA_W:0]   high_bits;
   logic [DATA_W-1:0]        o_mean_ff, o_mean_in;

   assign o_ready  = !o_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || o_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign in_ready = b_ready;

   assign c_prod_in = b_sum_ff * $signed({1'b0, scale});

   // Round half up, then clamp to the 32-bit signed range.
   always_comb begin
      rounded   = c_prod_ff + $signed(trma_pkg::ROUND_BIAS);
      shifted   = rounded >>> trma_pkg::FRAC_BITS;
      high_bits = shifted[PROD_W-1:DATA_W-1];
      if ((&high_bits) || !(|high_bits)) begin
         o_mean_in = shifted[DATA_W-1:0];
      end else if (shifted[PROD_W-1]) begin
         o_mean_in = trma_pkg::MEAN_MIN;
      end else begin
         o_mean_in = trma_pkg::MEAN_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (b_ready) begin
            b_valid_ff <= in_valid;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (o_ready) begin
            o_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_sum_ff  <= in_word.sum;
         b_last_ff <= in_word.tensor_last;
      end
      if (c_ready) begin
         c_prod_ff <= c_prod_in;
         c_last_ff <= b_last_ff;
      end
      if (o_ready) begin
         o_mean_ff <= o_mean_in;
         o_last_ff <= c_last_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_mean  = o_mean_ff;
   assign out_last  = o_last_ff;

endmodule

// ===== rtl/tensor_reduce_mean_axis_core.sv =====
`timescale 1ns / 1ps

// Mean of an N x H x W tensor along one axis, signed Q16.16 in and out.
// req_chan takes one tensor element per word, row-major (slice, row, column).
// rsp_chan gives one mean per row (axis_select = 1, at each row's last column)
// or one mean per column (axis_select = 0, during each slice's last row);
// tensor_last marks the final mean of the whole tensor.
// csr_chan writes the five registers by index and is always ready; it is to be
// written only while no element is in flight, which the block does not enforce.
// Throughput is one element per cycle unless a mean waits in the accumulate
// stage. A mean reaches rsp_chan, after the element that ends its group is taken,
// through the accumulate stage with the column-sum RAM read, the sum register,
// the multiply register, then the rounded and saturated output register.
// When rsp_chan stalls, the three scale stages fill before req_chan drops
// ready; elements that end no group keep flowing while means wait in them.
// Reset clears the positions, the row sum, all valid bits and the registers
// (axis 1, H = W = N = 1, scale one). The column-sum RAM is not cleared: each
// column is written at the first row of a slice before it is read.
module tensor_reduce_mean_axis_core #(
   parameter int MAX_WIDTH  = trma_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = trma_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_BATCH  = trma_pkg::MAX_BATCH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   trma_req_if.sink    req_chan,
   trma_rsp_if.source  rsp_chan,
   trma_csr_if.sink    csr_chan
);

   trma_pkg::cfg_type        cfg_ff, cfg_in;
   logic                     mid_valid, mid_ready;
   trma_pkg::accum_word_type mid_word;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (trma_pkg::csr_index_type'(csr_chan.index))
            trma_pkg::CSR_AXIS: begin
               cfg_in.axis_select = csr_chan.data[0];
            end
            trma_pkg::CSR_HEIGHT: begin
               cfg_in.height_count = csr_chan.data[trma_pkg::DIM_REG_W-1:0];
            end
            trma_pkg::CSR_WIDTH: begin
               cfg_in.width_count = csr_chan.data[trma_pkg::DIM_REG_W-1:0];
            end
            trma_pkg::CSR_BATCH: begin
               cfg_in.batch_count = csr_chan.data[trma_pkg::BATCH_REG_W-1:0];
            end
            trma_pkg::CSR_SCALE: begin
               cfg_in.reciprocal_scale = csr_chan.data[trma_pkg::SCALE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_select      <= trma_pkg::AXIS_RESET;
         cfg_ff.height_count     <= trma_pkg::DIM_RESET;
         cfg_ff.width_count      <= trma_pkg::DIM_RESET;
         cfg_ff.batch_count      <= trma_pkg::BATCH_RESET;
         cfg_ff.reciprocal_scale <= trma_pkg::SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trma_accum #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_BATCH  (MAX_BATCH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_sample (req_chan.sample_value),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_word  (mid_word)
   );

   trma_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .scale     (cfg_ff.reciprocal_scale),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_word   (mid_word),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_mean  (rsp_chan.mean_value),
      .out_last  (rsp_chan.tensor_last)
   );

`ifndef NO_ASSERTIONS
   // Reset empties the result pipeline.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("rsp valid after reset");

   // With the output register free to move, the scale stages must take a word.
   a_scale_not_blocked: assert property (@(posedge clock) disable iff (reset)
      (!rsp_chan.valid || rsp_chan.ready) |-> mid_ready)
      else $error("scale pipeline blocked while output can move");

   // A mean held in the accumulate stage blocks new elements.
   a_accum_holds_input: assert property (@(posedge clock) disable iff (reset)
      (mid_valid && !mid_ready) |-> !req_chan.ready)
      else $error("element accepted while accumulate stage stalled");
`endif

endmodule

// ===== tb/tensor_reduce_mean_axis_core_tb.sv =====
`timescale 1ns / 1ps

module tensor_reduce_mean_axis_core_tb;

   typedef struct packed {
      logic signed [trma_pkg::DATA_W-1:0] mean_value;
      logic                               tensor_last;
   } mean_word_type;

   logic clock;
   logic reset;

   trma_req_if req_bus ();
   trma_rsp_if rsp_bus ();
   trma_csr_if csr_bus ();

   tensor_reduce_mean_axis_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow of the block's registers and accumulation state.
   trma_pkg::cfg_type                 shadow_cfg;
   logic signed [trma_pkg::SUM_W-1:0] column_sums [trma_pkg::MAX_WIDTH_DEF];
   logic signed [trma_pkg::SUM_W-1:0] row_sum;
   int unsigned                       column_pos;
   int unsigned                       row_pos;
   int unsigned                       slice_pos;

   mean_word_type               expected_means [$];
   logic [trma_pkg::DATA_W-1:0] pending_elements [$];
   int unsigned                 elements_queued = 0;
   int unsigned                 elements_taken = 0;
   int unsigned                 csr_writes = 0;
   int unsigned                 mismatch_count = 0;
   int unsigned                 random_elements = 0;

   bit idle_enabled = 1'b1;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   bit req_fire;
   int req_gap = 0;
   int rsp_gap = 0;
   int hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tensor_reduce_mean_axis_core: mismatch");
      $finish;
   end

   function automatic int unsigned effective_count(input int unsigned value,
                                                   input int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic logic [trma_pkg::DATA_W-1:0] scaled_mean(
      input logic signed [trma_pkg::SUM_W-1:0] sum);
      longint product;
      longint rounded;
      product = longint'(sum) * longint'(shadow_cfg.reciprocal_scale) + 64'sd32768;
      // The arithmetic shift floors, so with the half bias ties go toward plus infinity.
      rounded = product >>> trma_pkg::FRAC_BITS;
      if (rounded > 64'sd2147483647) return trma_pkg::MEAN_MAX;
      if (rounded < -64'sd2147483648) return trma_pkg::MEAN_MIN;
      return rounded[trma_pkg::DATA_W-1:0];
   endfunction

   task automatic absorb_element(input logic signed [trma_pkg::DATA_W-1:0] element);
      int unsigned                       h;
      int unsigned                       w;
      int unsigned                       n;
      int unsigned                       col;
      bit                                col_end;
      bit                                row_end;
      bit                                slice_end;
      logic signed [trma_pkg::SUM_W-1:0] wide;
      logic signed [trma_pkg::SUM_W-1:0] total;
      mean_word_type                     word;
      h = effective_count(shadow_cfg.height_count, trma_pkg::MAX_HEIGHT_DEF);
      w = effective_count(shadow_cfg.width_count, trma_pkg::MAX_WIDTH_DEF);
      n = effective_count(shadow_cfg.batch_count, trma_pkg::MAX_BATCH_DEF);
      wide = element;
      col_end = column_pos >= w - 1;
      row_end = row_pos >= h - 1;
      slice_end = slice_pos >= n - 1;
      col = (column_pos >= trma_pkg::MAX_WIDTH_DEF) ? trma_pkg::MAX_WIDTH_DEF - 1
                                                   : column_pos;
      word.tensor_last = col_end && row_end && slice_end;
      if (shadow_cfg.axis_select == 1'b0) begin
         // The first row of a slice overwrites the column entry instead of adding.
         total = (row_pos == 0) ? wide : column_sums[col] + wide;
         column_sums[col] = total;
         if (row_end) begin
            word.mean_value = scaled_mean(total);
            expected_means.push_back(word);
         end
      end else begin
         row_sum = row_sum + wide;
         if (col_end) begin
            word.mean_value = scaled_mean(row_sum);
            expected_means.push_back(word);
            row_sum = '0;
         end
      end
      if (col_end) begin
         column_pos = 0;
         if (row_end) begin
            row_pos = 0;
            slice_pos = slice_end ? 0 : slice_pos + 1;
         end else begin
            row_pos++;
         end
      end else begin
         column_pos++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg.axis_select = trma_pkg::AXIS_RESET;
         shadow_cfg.height_count = trma_pkg::DIM_RESET;
         shadow_cfg.width_count = trma_pkg::DIM_RESET;
         shadow_cfg.batch_count = trma_pkg::BATCH_RESET;
         shadow_cfg.reciprocal_scale = trma_pkg::SCALE_RESET;
         row_sum = '0;
         column_pos = 0;
         row_pos = 0;
         slice_pos = 0;
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               trma_pkg::CSR_AXIS:
                  shadow_cfg.axis_select = csr_bus.data[0];
               trma_pkg::CSR_HEIGHT:
                  shadow_cfg.height_count = csr_bus.data[trma_pkg::DIM_REG_W-1:0];
               trma_pkg::CSR_WIDTH:
                  shadow_cfg.width_count = csr_bus.data[trma_pkg::DIM_REG_W-1:0];
               trma_pkg::CSR_BATCH:
                  shadow_cfg.batch_count = csr_bus.data[trma_pkg::BATCH_REG_W-1:0];
               trma_pkg::CSR_SCALE:
                  shadow_cfg.reciprocal_scale = csr_bus.data[trma_pkg::SCALE_W-1:0];
               default: ;
            endcase
            csr_writes++;
         end
         if (req_bus.valid && req_bus.ready) begin
            absorb_element(req_bus.sample_value);
            elements_taken++;
         end
      end
   end

   always @(posedge clock) begin : check_means
      mean_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_means.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected mean word, expected none, actual %h last %b",
                     $time, rsp_bus.mean_value, rsp_bus.tensor_last);
         end else begin
            want = expected_means.pop_front();
            if (rsp_bus.mean_value !== want.mean_value) begin
               mismatch_count++;
               $display("%0t: mean_value expected %h, actual %h",
                        $time, want.mean_value, rsp_bus.mean_value);
            end
            if (rsp_bus.tensor_last !== want.tensor_last) begin
               mismatch_count++;
               $display("%0t: tensor_last expected %b, actual %b",
                        $time, want.tensor_last, rsp_bus.tensor_last);
            end
         end
      end
   end

   // A word stays on the bus until taken; pauses only fall between words.
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_fire)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 11) == 0) begin
            req_gap = $urandom_range(0, 16);
            req_bus.valid <= 1'b0;
         end else if (pending_elements.size() != 0) begin
            req_bus.sample_value <= pending_elements.pop_front();
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_request && !hold_done) begin
            // Long hold so that the scale stages fill and the input backs up.
            if (hold_cycles < 120) begin
               hold_cycles++;
               rsp_bus.ready <= 1'b0;
            end else begin
               hold_done = 1'b1;
               rsp_bus.ready <= 1'b1;
            end
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 11) == 0) begin
            rsp_gap = $urandom_range(0, 16);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic [trma_pkg::DATA_W-1:0] draw_element();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return trma_pkg::DATA_W'($urandom_range(0, 262143))
                      - trma_pkg::DATA_W'(131072);
         default: return $urandom();
      endcase
   endfunction

   task automatic write_reg(input trma_pkg::csr_index_type idx, input int unsigned value);
      int unsigned target;
      target = csr_writes + 1;
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= trma_pkg::CSR_DATA_W'(value);
      do @(negedge clock); while (csr_writes != target);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_config(input int unsigned axis, input int unsigned h,
                              input int unsigned w, input int unsigned n,
                              input int unsigned scale);
      write_reg(trma_pkg::CSR_AXIS, axis);
      write_reg(trma_pkg::CSR_HEIGHT, h);
      write_reg(trma_pkg::CSR_WIDTH, w);
      write_reg(trma_pkg::CSR_BATCH, n);
      write_reg(trma_pkg::CSR_SCALE, scale);
   endtask

   task automatic push_element(input logic [trma_pkg::DATA_W-1:0] element);
      pending_elements.push_back(element);
      elements_queued++;
   endtask

   task automatic drain_results();
      while (elements_taken != elements_queued || expected_means.size() != 0)
         @(negedge clock);
      // Elements that end no group may still sit in the pipeline.
      repeat (8) @(posedge clock);
   endtask

   task automatic run_tensors(input int unsigned axis, input int unsigned h,
                              input int unsigned w, input int unsigned n,
                              input int unsigned scale, input int unsigned tensors);
      int unsigned total;
      load_config(axis, h, w, n, scale);
      total = effective_count(h, trma_pkg::MAX_HEIGHT_DEF)
              * effective_count(w, trma_pkg::MAX_WIDTH_DEF)
              * effective_count(n, trma_pkg::MAX_BATCH_DEF) * tensors;
      repeat (total) push_element(draw_element());
      random_elements += total;
      drain_results();
   endtask

   task automatic run_small_tensors();
      int unsigned axis;
      int unsigned h;
      int unsigned w;
      int unsigned n;
      int unsigned len;
      int unsigned scale;
      axis = $urandom_range(0, 1);
      h = $urandom_range(0, 5);
      w = $urandom_range(0, 8);
      n = $urandom_range(0, 3);
      len = axis ? effective_count(w, trma_pkg::MAX_WIDTH_DEF)
                 : effective_count(h, trma_pkg::MAX_HEIGHT_DEF);
      if ($urandom_range(0, 3) == 0) scale = $urandom_range(0, 131071);
      else scale = (65536 + len / 2) / len;
      run_tensors(axis, h, w, n, scale, $urandom_range(1, 3));
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.sample_value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = trma_pkg::CSR_AXIS;
      csr_bus.data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings give a scale of one, so each element comes back unchanged.
      push_element(32'h7FFF_FFFF);
      push_element(32'h8000_0000);
      push_element(32'h0000_0000);
      push_element(32'hFFFF_FFFF);
      push_element(32'h0000_0001);
      push_element(32'h0001_0000);
      drain_results();

      write_reg(trma_pkg::CSR_SCALE, 0);
      push_element(32'h1234_5678);
      drain_results();

      // A scale above one saturates both ways.
      write_reg(trma_pkg::CSR_SCALE, 131071);
      push_element(32'h7FFF_FFFF);
      push_element(32'h8000_0000);
      drain_results();

      // Half scale: exact ties round up.
      write_reg(trma_pkg::CSR_SCALE, 32768);
      push_element(32'h0000_0001);
      push_element(32'hFFFF_FFFF);
      push_element(32'h0000_0003);
      drain_results();

      write_reg(trma_pkg::CSR_SCALE, 1);
      push_element(32'h7FFF_FFFF);
      drain_results();

      // Counts of zero behave as one.
      load_config(1, 0, 0, 0, 65536);
      push_element(32'hDEAD_BEEF);
      drain_results();

      load_config(0, 2, 2, 1, 32768);
      push_element(32'h7FFF_FFFF);
      push_element(32'h8000_0000);
      push_element(32'h7FFF_FFFF);
      push_element(32'h8000_0000);
      drain_results();

      // Shrink the width in the middle of a row: the position wraps at once.
      load_config(1, 2, 3, 2, 21845);
      repeat (4) push_element(draw_element());
      drain_results();
      write_reg(trma_pkg::CSR_WIDTH, 1);
      // One word closes slice zero, then two one-word rows make slice one.
      repeat (3) push_element(draw_element());
      drain_results();

      while (random_elements < 300) run_small_tensors();
      run_tensors(0, 1, 2047, 1, $urandom_range(1, 131071), 1);
      hold_request = 1'b1;
      run_tensors(1, 150, 1, 1, 65536, 1);
      run_tensors(0, 1, 1, 511, 1, 1);
      while (random_elements < 1820) run_small_tensors();
      idle_enabled = 1'b0;
      while (random_elements < 1920) run_small_tensors();

      if (mismatch_count == 0) begin
         $display("tensor_reduce_mean_axis_core: match");
      end else begin
         $display("tensor_reduce_mean_axis_core: mismatch");
      end
      $finish;
   end

endmodule
